[hw/rtl/assert_macros.svh]
// assertion macros used by the timer top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mcct_pkg.sv]
// types, constants and helpers of the multi-channel compare timer
package mcct_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_STATUS = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  localparam logic [1:0]  MODE_ACTIVE   = 2'd0;
  localparam logic [1:0]  MODE_LP_SLEEP = 2'd2;
  localparam logic [1:0]  MODE_INVALID  = 2'd3;
  localparam logic [15:0] LP_LATENCY_MS = 16'd2;
  localparam logic [15:0] MIN_MS        = 16'd1;
  localparam logic [15:0] CNT_MOD       = 16'hFFFF;
  localparam logic [15:0] RATE_RESET    = 16'd2048;
  localparam int          MASK_W        = 4;

  // duration * rate limit: 65535 * 1000
  localparam logic [32:0] DUR_MAX_PRODUCT = 33'd65535000;

  // floor(x / 1000) = (x * RECIP) >> RECIP_SHIFT, exact for any 32-bit x
  localparam int          PROD_W      = 32;
  localparam int          RECIP_W     = 29;
  localparam int          RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
  localparam int          PRODM_W     = PROD_W + RECIP_W;
  localparam int          QUOT_W      = PRODM_W - RECIP_SHIFT;

  typedef struct packed {
    logic        reload;
    logic [2:0]  opcode;
    logic [2:0]  channel;
    logic [15:0] dur_ms;
    logic [1:0]  wait_mode;
  } item_t;

  typedef struct packed {
    logic        reload;
    logic [2:0]  opcode;
    logic [2:0]  channel;
    logic [15:0] dur_eff;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic        bad_arg;
    logic [15:0] ticks;
  } exec_t;

  typedef struct packed {
    logic [15:0]       counter_now;
    logic [MASK_W-1:0] running_mask;
    logic [MASK_W-1:0] fired_mask;
    logic              elapsed;
    logic              status;
  } res_t;

  // (a + b) mod 65535 for a <= 65535, b < 65535
  function automatic logic [15:0] mod_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, CNT_MOD}) ? 16'(s - {1'b0, CNT_MOD}) : s[15:0];
  endfunction

endpackage

[hw/rtl/mcct_pipe.sv]
// item pipeline: input register and the ms-to-ticks arithmetic stages
module mcct_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mcct_pkg::item_t     in_item_i,
  input  logic [15:0]         rate_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mcct_pkg::exec_t     out_item_o
);

  logic [3:0] v_q, v_d;
  logic [3:0] rdy;

  mcct_pkg::item_t s0_q;

  mcct_pkg::tag_t                   t1_q;
  logic                             early1_q;
  logic                             lp1_q;
  logic [mcct_pkg::PROD_W-1:0]      prod1_q;
  logic [15:0]                      rate1_q;

  mcct_pkg::tag_t                   t2_q;
  logic                             err2_q;
  logic [mcct_pkg::QUOT_W-1:0]      quot2_q;

  mcct_pkg::exec_t                  s3_q;

  logic        lp0;
  logic [15:0] dur_eff0;
  logic [15:0] min0;
  logic        early0;

  logic [32:0]                      raw1;
  logic [mcct_pkg::PRODM_W-1:0]     mul1;

  logic [16:0] fold2;
  logic [15:0] ticks2;

  // ready chain, each stage moves when the next one frees up
  assign rdy[3] = !v_q[3] || out_ready_i;
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[3];
  assign out_item_o  = s3_q;

  always_comb begin
    v_d = v_q;
    if (rdy[0]) v_d[0] = in_valid_i;
    if (rdy[1]) v_d[1] = v_q[0];
    if (rdy[2]) v_d[2] = v_q[1];
    if (rdy[3]) v_d[3] = v_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage 0 arithmetic: effective period and simple start checks
  always_comb begin
    lp0      = (s0_q.wait_mode == mcct_pkg::MODE_LP_SLEEP);
    dur_eff0 = lp0 ? (s0_q.dur_ms - mcct_pkg::LP_LATENCY_MS) : s0_q.dur_ms;
    min0     = lp0 ? (mcct_pkg::MIN_MS + mcct_pkg::LP_LATENCY_MS) : mcct_pkg::MIN_MS;
    early0   = (s0_q.wait_mode == mcct_pkg::MODE_INVALID) || (s0_q.dur_ms < min0);
  end

  // stage 1 arithmetic: reciprocal multiply and raw-duration limit check
  always_comb begin
    raw1 = {1'b0, prod1_q} + (lp1_q ? {16'b0, rate1_q, 1'b0} : 33'd0);
    mul1 = mcct_pkg::PRODM_W'(prod1_q) * mcct_pkg::PRODM_W'(mcct_pkg::RECIP);
  end

  // stage 2 arithmetic: quotient folded mod 65535
  always_comb begin
    fold2  = 17'(quot2_q[mcct_pkg::QUOT_W-1:16]) + 17'(quot2_q[15:0]);
    ticks2 = (fold2 >= {1'b0, mcct_pkg::CNT_MOD}) ?
             16'(fold2 - {1'b0, mcct_pkg::CNT_MOD}) : fold2[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_q <= in_item_i;
    end
    if (rdy[1]) begin
      t1_q     <= '{reload: s0_q.reload, opcode: s0_q.opcode,
                    channel: s0_q.channel, dur_eff: dur_eff0};
      early1_q <= early0;
      lp1_q    <= lp0;
      prod1_q  <= mcct_pkg::PROD_W'(dur_eff0) * mcct_pkg::PROD_W'(rate_i);
      rate1_q  <= rate_i;
    end
    if (rdy[2]) begin
      t2_q    <= t1_q;
      err2_q  <= early1_q || (raw1 > mcct_pkg::DUR_MAX_PRODUCT);
      quot2_q <= mul1[mcct_pkg::RECIP_SHIFT +: mcct_pkg::QUOT_W];
    end
    if (rdy[3]) begin
      s3_q <= '{tag: t2_q, bad_arg: err2_q, ticks: ticks2};
    end
  end

endmodule

[hw/rtl/mcct_exec.sv]
// channel state, shared counter and per-item execution
module mcct_exec #(
  parameter int CHANNELS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  mcct_pkg::exec_t           item_i,
  input  logic [2:0]                reload_idx_i,
  output logic [15:0]               reload_period_o,
  output mcct_pkg::res_t            res_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0]         counter_q, counter_d;
  logic [15:0]         cmp_q    [CHANNELS];
  logic [15:0]         cmp_d    [CHANNELS];
  logic [15:0]         period_q [CHANNELS];
  logic [15:0]         period_d [CHANNELS];
  logic [15:0]         ticks_q  [CHANNELS];
  logic [15:0]         ticks_d  [CHANNELS];
  logic [CHANNELS-1:0] running_q, running_d;
  logic [CHANNELS-1:0] flag_q, flag_d;
  logic [CHANNELS-1:0] fired;

  logic [mcct_pkg::MASK_W-1:0] run4_now, run4_next, fired4;

  logic            ch_ok;
  logic [CH_W-1:0] idx;
  logic            status;
  logic            elapsed;

  assign ch_ok = (4'(item_i.tag.channel) < 4'(CHANNELS));
  assign idx   = item_i.tag.channel[CH_W-1:0];

  assign reload_period_o = period_q[reload_idx_i[CH_W-1:0]];

  // masks carry the low channels only
  for (genvar i = 0; i < mcct_pkg::MASK_W; i++) begin : g_mask
    if (i < CHANNELS) begin : g_on
      assign run4_now[i]  = running_q[i];
      assign run4_next[i] = running_d[i];
      assign fired4[i]    = fired[i];
    end else begin : g_off
      assign run4_now[i]  = 1'b0;
      assign run4_next[i] = 1'b0;
      assign fired4[i]    = 1'b0;
    end
  end

  always_comb begin
    counter_d = counter_q;
    cmp_d     = cmp_q;
    period_d  = period_q;
    ticks_d   = ticks_q;
    running_d = running_q;
    flag_d    = flag_q;
    fired     = '0;
    status    = 1'b0;
    elapsed   = 1'b0;
    if (item_i.tag.reload) begin
      ticks_d[idx] = item_i.ticks;
    end else begin
      case (item_i.tag.opcode)
        mcct_pkg::OP_TICK: begin
          if (run4_now != '0) begin
            counter_d = counter_q + 16'd1;
            for (int i = 0; i < CHANNELS; i++) begin
              if (running_q[i] && (cmp_q[i] == counter_d)) begin
                flag_d[i] = 1'b1;
                cmp_d[i]  = mcct_pkg::mod_add(counter_d, ticks_q[i]);
                fired[i]  = 1'b1;
              end
            end
          end
        end
        mcct_pkg::OP_START: begin
          if (!ch_ok || item_i.bad_arg) begin
            status = 1'b1;
          end else begin
            period_d[idx]  = item_i.tag.dur_eff;
            ticks_d[idx]   = item_i.ticks;
            running_d[idx] = 1'b1;
            flag_d[idx]    = 1'b0;
            cmp_d[idx]     = mcct_pkg::mod_add(counter_q, item_i.ticks);
          end
        end
        mcct_pkg::OP_STOP: begin
          if (!ch_ok) begin
            status = 1'b1;
          end else begin
            running_d[idx] = 1'b0;
            flag_d[idx]    = 1'b0;
          end
        end
        mcct_pkg::OP_STATUS: begin
          if (!ch_ok) begin
            status = 1'b1;
          end else begin
            elapsed = !running_q[idx] || flag_q[idx];
          end
        end
        mcct_pkg::OP_CLEAR: begin
          if (!ch_ok) begin
            status = 1'b1;
          end else begin
            flag_d[idx] = 1'b0;
          end
        end
        default: begin
          status = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res_o.status       = status;
    res_o.elapsed      = elapsed;
    res_o.fired_mask   = fired4;
    res_o.running_mask = run4_next;
    res_o.counter_now  = counter_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      cmp_q     <= '{default: '0};
      period_q  <= '{default: '0};
      ticks_q   <= '{default: '0};
      running_q <= '0;
      flag_q    <= '0;
    end else if (fire_i) begin
      counter_q <= counter_d;
      cmp_q     <= cmp_d;
      period_q  <= period_d;
      ticks_q   <= ticks_d;
      running_q <= running_d;
      flag_q    <= flag_d;
    end
  end

endmodule

[hw/rtl/multi_channel_compare_timer.sv]
// result path: an accepted item passes the input, multiply, reciprocal and fold regs,
//   then the result reg
// throughput: one item per cycle unless reloads or output back-pressure stall; the chain
//   of input, multiply, reciprocal and fold stages feeds a single execute step that updates
//   all channel state; a config write blocks input while per-channel tick counts reload
// reset: counter, compare values, periods, running and elapsed flags clear, rate = 2048
module multi_channel_compare_timer #(
  parameter int CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick rate register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [2:0] channel, [18:3] dur_ms, [20:19] wait_mode
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] opcode
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // [0] status, [1] elapsed, [5:2] fired_mask,
                                       // [9:6] running_mask, [25:10] counter_now
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // tick rate; the user must keep it constant while items are in flight, the block does not enforce it
  logic [15:0] rate_q, rate_d;

  // reload sequencer: recomputes ticks for every channel after a rate change
  logic            reload_busy_q, reload_busy_d;
  logic [CH_W-1:0] reload_idx_q, reload_idx_d;
  logic            reload_last;
  logic            inject;
  logic [15:0]     reload_period;

  // pipeline handshake
  logic            pipe_in_valid;
  logic            pipe_in_ready;
  mcct_pkg::item_t pipe_in_item;
  logic            pipe_out_valid;
  logic            exec_take;
  logic            exec_fire;
  mcct_pkg::exec_t pipe_out_item;

  // result register
  mcct_pkg::res_t  exec_res;
  mcct_pkg::res_t  res_q;
  logic            out_valid_q, out_valid_d;

  // rate register
  always_comb begin
    rate_d = rate_q;
    if (cfg_we_i) rate_d = cfg_wdata_i;
  end

  // reload sequencing, one channel injected per free pipeline slot
  assign reload_last = (reload_idx_q == CH_W'(CHANNELS - 1));
  assign inject      = reload_busy_q && pipe_in_ready;

  always_comb begin
    reload_busy_d = reload_busy_q;
    reload_idx_d  = reload_idx_q;
    if (cfg_we_i) begin
      reload_busy_d = 1'b1;
      reload_idx_d  = '0;
    end else if (inject) begin
      if (reload_last) begin
        reload_busy_d = 1'b0;
        reload_idx_d  = '0;
      end else begin
        reload_idx_d = reload_idx_q + CH_W'(1);
      end
    end
  end

  // input mux: stream items, or reload slots while the sequencer runs
  always_comb begin
    pipe_in_valid = reload_busy_q || s_axis_tvalid_i;
    if (reload_busy_q) begin
      pipe_in_item = '{reload: 1'b1, opcode: mcct_pkg::OP_TICK,
                       channel: 3'(reload_idx_q), dur_ms: reload_period,
                       wait_mode: mcct_pkg::MODE_ACTIVE};
    end else begin
      pipe_in_item = '{reload: 1'b0, opcode: s_axis_tuser_i,
                       channel: s_axis_tdata_i[2:0], dur_ms: s_axis_tdata_i[18:3],
                       wait_mode: s_axis_tdata_i[20:19]};
    end
  end

  assign s_axis_tready_o = pipe_in_ready && !reload_busy_q;

  mcct_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pipe_in_valid),
    .in_ready_o  (pipe_in_ready),
    .in_item_i   (pipe_in_item),
    .rate_i      (rate_q),
    .out_valid_o (pipe_out_valid),
    .out_ready_i (exec_take),
    .out_item_o  (pipe_out_item)
  );

  // reload slots never need room in the result register
  assign exec_take = pipe_out_item.tag.reload || !out_valid_q || m_axis_tready_i;
  assign exec_fire = pipe_out_valid && exec_take;

  mcct_exec #(
    .CHANNELS (CHANNELS)
  ) u_exec (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (exec_fire),
    .item_i          (pipe_out_item),
    .reload_idx_i    (3'(reload_idx_q)),
    .reload_period_o (reload_period),
    .res_o           (exec_res)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (exec_fire && !pipe_out_item.tag.reload) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q        <= mcct_pkg::RATE_RESET;
      reload_busy_q <= 1'b0;
      reload_idx_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      rate_q        <= rate_d;
      reload_busy_q <= reload_busy_d;
      reload_idx_q  <= reload_idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire && !pipe_out_item.tag.reload) begin
      res_q <= exec_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, res_q};

  // checks

`include "assert_macros.svh"

  // a rate change holds off input until ticks reload
  `ASSERT_NEXT(a_cfg_blocks_input, cfg_we_i, !s_axis_tready_o, "input open after rate write")

  // a channel that fires keeps running
  `ASSERT_NOW(a_fired_running, out_valid_q,
              (res_q.fired_mask & ~res_q.running_mask) == '0, "fired channel not running")

  // reload slots leave the result register alone
  `ASSERT_NEXT(a_reload_no_result, pipe_out_valid && pipe_out_item.tag.reload,
               out_valid_q == $past(out_valid_q && !m_axis_tready_i), "reload made a result")

endmodule

[tb/testbench.sv]
// self-checking testbench for the multi-channel compare timer
`timescale 1ns / 1ps

module testbench;

  localparam int CHANNELS = 4;
  // opcodes past clear are reserved and must come back as errors
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam logic [1:0] MODE_SLEEP = 2'd1;
  // worst case is far below this: ~1000 items, each with a maximal input gap and output stall
  localparam int CYCLE_LIMIT = 600000;
  // drain time after the last result
  localparam int DRAIN_CYCLES = 16;

  // one command item as seen on the input stream
  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  channel;
    logic [15:0] dur_ms;
    logic [1:0]  wait_mode;
  } timer_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  multi_channel_compare_timer #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),  // [2:0] channel, [18:3] dur_ms, [20:19] wait_mode
    .s_axis_tuser_i (s_axis_tuser_i),  // [2:0] opcode
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)   // [0] status, [1] elapsed, [5:2] fired_mask,
                                       // [9:6] running_mask, [25:10] counter_now
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the timer state, advanced in acceptance order
  logic [15:0] rate_model;
  logic [15:0] count_model;
  logic [15:0] compare_model [CHANNELS];
  logic [15:0] period_model [CHANNELS];
  logic [CHANNELS-1:0] running_model;
  logic [CHANNELS-1:0] flag_model;

  timer_cmd_t     pending_cmds[$];      // items waiting for the driver
  mcct_pkg::res_t timer_results_due[$]; // predicted results, oldest first
  timer_cmd_t     bus_cmd;              // item currently presented on the input stream
  logic           quiet = 1'b0;         // no idling on either side when set
  int             in_gap = 0;
  int             out_stall = 0;
  int             cycles = 0;
  int             mismatches = 0;
  int             results_seen = 0;
  int             fire_events = 0;
  int             starts_ok = 0;
  int             rates_used = 0;

  // compare value for a period armed from the current counter
  function automatic logic [15:0] arm_compare(input logic [15:0] period);
    logic [63:0] ticks;
    ticks = (64'(period) * 64'(rate_model)) / 64'd1000;
    return 16'((64'(count_model) + ticks) % 64'(mcct_pkg::CNT_MOD));
  endfunction

  // apply one command to the shadow state and return what the block must answer
  function automatic mcct_pkg::res_t predict_timer_result(input timer_cmd_t c);
    mcct_pkg::res_t r;
    logic           ch_ok;
    logic [1:0]     ch;
    logic [15:0]    min_ms;
    logic [63:0]    prod;
    r = '0;
    ch_ok = (c.channel < CHANNELS);
    ch = c.channel[1:0];
    case (c.opcode)
      mcct_pkg::OP_TICK: begin
        // counter frozen while nothing runs
        if (running_model != '0) begin
          count_model = count_model + 16'd1;
          for (int i = 0; i < CHANNELS; i++) begin
            if (running_model[i] && compare_model[i] == count_model) begin
              flag_model[i] = 1'b1;
              compare_model[i] = arm_compare(period_model[i]);
              r.fired_mask[i] = 1'b1;
            end
          end
        end
      end
      mcct_pkg::OP_START: begin
        min_ms = mcct_pkg::MIN_MS +
                 ((c.wait_mode == mcct_pkg::MODE_LP_SLEEP) ? mcct_pkg::LP_LATENCY_MS : 16'd0);
        prod = 64'(c.dur_ms) * 64'(rate_model);
        if (!ch_ok || c.wait_mode == mcct_pkg::MODE_INVALID || c.dur_ms < min_ms ||
            prod > 64'(mcct_pkg::DUR_MAX_PRODUCT)) begin
          r.status = 1'b1;
        end else begin
          // low-power sleep eats the wake-up latency out of the period
          period_model[ch] = (c.wait_mode == mcct_pkg::MODE_LP_SLEEP) ?
                             c.dur_ms - mcct_pkg::LP_LATENCY_MS : c.dur_ms;
          running_model[ch] = 1'b1;
          flag_model[ch] = 1'b0;
          compare_model[ch] = arm_compare(period_model[ch]);
        end
      end
      mcct_pkg::OP_STOP: begin
        if (!ch_ok) begin
          r.status = 1'b1;
        end else begin
          running_model[ch] = 1'b0;
          flag_model[ch] = 1'b0;
        end
      end
      mcct_pkg::OP_STATUS: begin
        if (!ch_ok) r.status = 1'b1;
        else r.elapsed = !running_model[ch] || flag_model[ch];
      end
      mcct_pkg::OP_CLEAR: begin
        if (!ch_ok) r.status = 1'b1;
        else flag_model[ch] = 1'b0;
      end
      default: r.status = 1'b1;
    endcase
    r.running_mask = running_model;
    r.counter_now = count_model;
    return r;
  endfunction

  // input side: feeds pending items, idles in random bursts
  always @(posedge clk_i) begin : drive_proc
    timer_cmd_t next_cmd;
    if (rst_ni && (!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (!quiet && pending_cmds.size() != 0 && $urandom_range(0, 19) == 0) begin
        in_gap <= $urandom_range(0, 18);
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        bus_cmd <= next_cmd;
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {3'b000, next_cmd.wait_mode, next_cmd.dur_ms, next_cmd.channel};
        s_axis_tuser_i <= next_cmd.opcode;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      timer_results_due.push_back(predict_timer_result(bus_cmd));
      if (bus_cmd.opcode == mcct_pkg::OP_START && timer_results_due[$].status == 1'b0)
        starts_ok <= starts_ok + 1;
    end
  end

  // output side: random stall bursts independent of valid
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall <= 0;
      m_axis_tready_i <= 1'b1;
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall <= $urandom_range(0, 18);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // compare each accepted result against the oldest prediction
  always @(posedge clk_i) begin : monitor_proc
    mcct_pkg::res_t want;
    mcct_pkg::res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[25:0];
      results_seen <= results_seen + 1;
      if (timer_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata_o);
        mismatches++;
      end else begin
        want = timer_results_due.pop_front();
        if (want.fired_mask != '0) fire_events <= fire_events + 1;
        check_field("status", want.status, got.status);
        check_field("elapsed", want.elapsed, got.elapsed);
        check_field("fired_mask", want.fired_mask, got.fired_mask);
        check_field("running_mask", want.running_mask, got.running_mask);
        check_field("counter_now", want.counter_now, got.counter_now);
        check_field("tdata padding", 0, m_axis_tdata_o[31:26]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_channel_compare_timer verification failed");
      $finish;
    end
  end

  task automatic push_cmd(input logic [2:0] op, input logic [2:0] ch,
                          input logic [15:0] dur, input logic [1:0] mode);
    timer_cmd_t c;
    c.opcode = op;
    c.channel = ch;
    c.dur_ms = dur;
    c.wait_mode = mode;
    pending_cmds.push_back(c);
  endtask

  // all items sent and answered, pipeline empty
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || s_axis_tvalid_i || timer_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // rate register only changes while the block is idle
  task automatic write_tick_rate(input logic [15:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    rate_model = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rates_used++;
  endtask

  // a start duration: mostly short periods so matches happen, some near the limit
  function automatic logic [15:0] pick_duration();
    int unsigned sel;
    int unsigned edge_ms;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 16'($urandom_range(1, 8));
    if (sel < 85 || rate_model == 16'd0) return 16'($urandom);
    // right at or one past the duration*rate limit
    edge_ms = 65535000 / rate_model + $urandom_range(0, 1);
    return (edge_ms > 65535) ? 16'hFFFF : 16'(edge_ms);
  endfunction

  task automatic queue_random_items(input int count);
    int unsigned sel;
    logic [2:0]  ch;
    logic [1:0]  mode;
    logic [15:0] dur;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      // mostly legal channels, sometimes out of range
      ch = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      mode = 2'($urandom);
      dur = 16'($urandom);
      if (sel < 50) begin
        push_cmd(mcct_pkg::OP_TICK, ch, dur, mode);
      end else if (sel < 68) begin
        mode = ($urandom_range(0, 19) == 0) ? mcct_pkg::MODE_INVALID :
               2'($urandom_range(0, 2));
        dur = pick_duration();
        if (mode == mcct_pkg::MODE_LP_SLEEP && $urandom_range(0, 1) == 1)
          dur = dur + mcct_pkg::LP_LATENCY_MS;
        push_cmd(mcct_pkg::OP_START, ch, dur, mode);
      end else if (sel < 76) begin
        push_cmd(mcct_pkg::OP_STOP, ch, dur, mode);
      end else if (sel < 86) begin
        push_cmd(mcct_pkg::OP_STATUS, ch, dur, mode);
      end else if (sel < 94) begin
        push_cmd(mcct_pkg::OP_CLEAR, ch, dur, mode);
      end else begin
        push_cmd(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), ch, dur, mode);
      end
    end
  endtask

  initial begin
    rate_model = mcct_pkg::RATE_RESET;
    count_model = '0;
    running_model = '0;
    flag_model = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      compare_model[i] = '0;
      period_model[i] = '0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset rate of 2048 Hz
    @(negedge clk_i);
    // nothing runs, counter holds
    push_cmd(mcct_pkg::OP_TICK, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    // idle channel reads as elapsed
    push_cmd(mcct_pkg::OP_STATUS, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    // minimum period, 2 ticks
    push_cmd(mcct_pkg::OP_START, 3'd0, 16'd1, mcct_pkg::MODE_ACTIVE);
    // mode ignored outside start
    push_cmd(mcct_pkg::OP_STATUS, 3'd0, 16'hFFFF, mcct_pkg::MODE_INVALID);
    push_cmd(mcct_pkg::OP_TICK, 3'd7, 16'hFFFF, mcct_pkg::MODE_INVALID);
    // channel 0 fires
    push_cmd(mcct_pkg::OP_TICK, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_STATUS, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_CLEAR, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_STATUS, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    // low-power minimum, then below it
    push_cmd(mcct_pkg::OP_START, 3'd1, 16'd3, mcct_pkg::MODE_LP_SLEEP);
    push_cmd(mcct_pkg::OP_START, 3'd2, 16'd2, mcct_pkg::MODE_LP_SLEEP);
    // zero duration, then invalid mode
    push_cmd(mcct_pkg::OP_START, 3'd3, 16'd0, MODE_SLEEP);
    push_cmd(mcct_pkg::OP_START, 3'd3, 16'd5, mcct_pkg::MODE_INVALID);
    // bad channel on start, stop, status and clear
    push_cmd(mcct_pkg::OP_START, 3'd4, 16'd5, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_STOP, 3'd7, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_STATUS, 3'd5, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_CLEAR, 3'd6, 16'd0, mcct_pkg::MODE_ACTIVE);
    // one past the product limit, then the largest legal one, compare folds
    push_cmd(mcct_pkg::OP_START, 3'd3, 16'd32000, MODE_SLEEP);
    push_cmd(mcct_pkg::OP_START, 3'd3, 16'd31999, MODE_SLEEP);
    push_cmd(mcct_pkg::OP_START, 3'd2, 16'hFFFF, mcct_pkg::MODE_ACTIVE);
    push_cmd(OP_RSVD_LO, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(OP_RSVD_HI, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_TICK, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_TICK, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_STOP, 3'd0, 16'd0, mcct_pkg::MODE_INVALID);
    push_cmd(mcct_pkg::OP_STOP, 3'd1, 16'd0, mcct_pkg::MODE_ACTIVE);
    push_cmd(mcct_pkg::OP_STOP, 3'd3, 16'd0, mcct_pkg::MODE_ACTIVE);
    // all stopped, counter halts
    push_cmd(mcct_pkg::OP_TICK, 3'd0, 16'd0, mcct_pkg::MODE_ACTIVE);

    // random phases across the rate range, each written while idle
    write_tick_rate(16'd32768);
    queue_random_items(150);
    write_tick_rate(16'd1);
    queue_random_items(70);
    write_tick_rate(16'd1000);
    queue_random_items(150);
    write_tick_rate(16'd0);
    queue_random_items(60);
    write_tick_rate(16'hFFFF);
    queue_random_items(110);
    write_tick_rate(16'($urandom_range(1, 32768)));
    queue_random_items(150);
    write_tick_rate(mcct_pkg::RATE_RESET);
    wait_drained();
    // last stretch runs back to back on both sides
    quiet = 1'b1;
    queue_random_items(240);

    wait_drained();
    if (timer_results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, timer_results_due.size());
      mismatches++;
    end
    $display("covered %0d results over %0d tick rates, %0d accepted starts, %0d fire events",
             results_seen, rates_used + 1, starts_ok, fire_events);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("multi_channel_compare_timer verification clean");
    end else begin
      $display("multi_channel_compare_timer verification failed");
    end
    $finish;
  end

endmodule
